FILE: hw/rtl/tve_pkg.sv
// ----------------------------------------------------------------------------
// TLV tag/value extractor package
// Shared types and codes for the extractor, its window cells and its checker.
// ----------------------------------------------------------------------------
package tve_pkg;

  // one window position: a byte and whether it holds data yet
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } cell_t;

  typedef logic [1:0] status_t;

  localparam status_t StValue    = 2'd0;
  localparam status_t StNotFound = 2'd1;
  localparam status_t StTrunc    = 2'd2;
  localparam status_t StEmpty    = 2'd3;

  localparam logic [1:0] CfgTagPattern = 2'd0;
  localparam logic [1:0] CfgTagLength  = 2'd1;
  localparam logic [1:0] CfgFixedLen   = 2'd2;

  localparam int unsigned TagRegBytes = 4;

endpackage

FILE: hw/rtl/tve_cell.sv
// ----------------------------------------------------------------------------
// TLV window cell
// Holds one byte of the search window, passes it on to the next cell on each
// shift and compares the byte it is about to take with its tag byte.
// ----------------------------------------------------------------------------
module tve_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           clear_i,
  input  logic [7:0]     tag_byte_i,
  input  tve_pkg::cell_t prev_i,
  output tve_pkg::cell_t cell_o,
  output logic           match_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q, data_d;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    if (clear_i) begin
      vld_d = 1'b0;
    end else if (shift_i) begin
      vld_d  = prev_i.vld;
      data_d = prev_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign cell_o.vld  = vld_q;
  assign cell_o.data = data_q;
  assign match_o     = prev_i.vld && (prev_i.data == tag_byte_i);

endmodule

FILE: hw/rtl/tlv_tag_value_extractor.sv
// ----------------------------------------------------------------------------
// TLV tag/value extractor
// Searches a byte stream for a configured tag of 1 to 4 bytes, then emits the
// value bytes that follow, with a fixed or an in-band length.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------
//  in       | in_valid_i / in_ready_o | data_byte_i, buffer_end_i
//  out      | out_valid_o/out_ready_i | value_byte_o, value_last_o, status_o
//  cfg      | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  One request per cycle unless stalled; each result appears in the cycle after
//  its request. The window compare over the cell chain and the phase update are
//  combinational. A full output register stalls input only while out_ready_i
//  is low. Reset restarts the search and sets the config registers to defaults.
// ----------------------------------------------------------------------------
module tlv_tag_value_extractor #(
  parameter int unsigned TAG_MAX_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        buffer_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  value_byte_o,
  output logic        value_last_o,
  output logic [1:0]  status_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned WinBytes =
    (TAG_MAX_BYTES < tve_pkg::TagRegBytes) ? TAG_MAX_BYTES : tve_pkg::TagRegBytes;

  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhLength = 2'd1;
  localparam logic [1:0] PhEmit   = 2'd2;
  localparam logic [1:0] PhDone   = 2'd3;

  logic [31:0] tag_pattern_q;
  logic [2:0]  tag_length_q;
  logic [7:0]  fixed_len_q;

  logic [1:0]  phase_q, phase_d;
  logic [7:0]  remain_q, remain_d;

  logic        out_valid_q;
  logic [7:0]  value_byte_q;
  logic        value_last_q;
  logic [1:0]  status_q;

  logic        in_fire;
  logic        res_vld;
  logic [7:0]  res_byte;
  logic        res_last;
  logic [1:0]  res_status;
  logic [2:0]  eff_len;
  logic        hit;
  logic        shift;

  tve_pkg::cell_t       chain  [WinBytes+1];
  logic [WinBytes-1:0]  match;
  logic [WinBytes-1:0]  in_use;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_pattern_q <= '0;
      tag_length_q  <= 3'd1;
      fixed_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tve_pkg::CfgTagPattern: tag_pattern_q <= cfg_data_i;
        tve_pkg::CfgTagLength:  tag_length_q  <= cfg_data_i[2:0];
        tve_pkg::CfgFixedLen:   fixed_len_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_len = tag_length_q;
    if (tag_length_q == 3'd0) begin
      eff_len = 3'd1;
    end else if (tag_length_q > 3'(WinBytes)) begin
      eff_len = 3'(WinBytes);
    end
  end

  // window cell chain, newest byte at cell 0
  assign shift         = in_fire && (phase_q == PhSearch);
  assign chain[0].vld  = 1'b1;
  assign chain[0].data = data_byte_i;

  for (genvar k = 0; k < WinBytes; k++) begin : g_cell
    tve_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift),
      .clear_i    (in_fire && buffer_end_i),
      .tag_byte_i (tag_pattern_q[8*k +: 8]),
      .prev_i     (chain[k]),
      .cell_o     (chain[k+1]),
      .match_o    (match[k])
    );
    assign in_use[k] = 3'(k) < eff_len;
  end

  assign hit = &(match | ~in_use);

  always_comb begin
    phase_d    = phase_q;
    remain_d   = remain_q;
    res_vld    = 1'b0;
    res_byte   = '0;
    res_last   = 1'b1;
    res_status = tve_pkg::StValue;
    if (in_fire) begin
      unique case (phase_q)
        PhSearch: begin
          if (hit) begin
            if (fixed_len_q != 8'd0) begin
              remain_d = fixed_len_q;
              phase_d  = PhEmit;
            end else begin
              phase_d = PhLength;
            end
            res_vld    = buffer_end_i;
            res_status = tve_pkg::StTrunc;
          end else begin
            res_vld    = buffer_end_i;
            res_status = tve_pkg::StNotFound;
          end
        end
        PhLength: begin
          if (data_byte_i == 8'd0) begin
            phase_d    = PhDone;
            res_vld    = 1'b1;
            res_status = tve_pkg::StEmpty;
          end else begin
            remain_d   = data_byte_i;
            phase_d    = PhEmit;
            res_vld    = buffer_end_i;
            res_status = tve_pkg::StTrunc;
          end
        end
        PhEmit: begin
          if (remain_q <= 8'd1) begin
            remain_d = '0;
            phase_d  = PhDone;
            res_vld  = 1'b1;
            res_byte = data_byte_i;
          end else if (buffer_end_i) begin
            res_vld    = 1'b1;
            res_status = tve_pkg::StTrunc;
          end else begin
            remain_d = remain_q - 8'd1;
            res_vld  = 1'b1;
            res_byte = data_byte_i;
            res_last = 1'b0;
          end
        end
        PhDone: ;
        default: ;
      endcase
      if (buffer_end_i) begin
        phase_d  = PhSearch;
        remain_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSearch;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      remain_q <= remain_d;
      if (in_fire && res_vld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_vld) begin
      value_byte_q <= res_byte;
      value_last_q <= res_last;
      status_q     <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_byte_o = value_byte_q;
  assign value_last_o = value_last_q;
  assign status_o     = status_q;

endmodule

FILE: hw/rtl/tve_checker.sv
// ----------------------------------------------------------------------------
// TLV extractor port checker
// Watches the extractor's ports for handshake and result-coding slips.
// ----------------------------------------------------------------------------
module tve_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] value_byte_o,
  input logic       value_last_o,
  input logic [1:0] status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(value_byte_o) && $stable(value_last_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input blocked without a stalled result");

  a_status_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tve_pkg::StValue) |-> value_byte_o == 8'd0)
    else $error("status result carries a nonzero byte");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != tve_pkg::StValue) |-> value_last_o)
    else $error("status result not marked last");

endmodule

bind tlv_tag_value_extractor tve_checker u_tve_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .value_byte_o (value_byte_o),
  .value_last_o (value_last_o),
  .status_o     (status_o)
);

FILE: verif/tb_tlv_tag_value_extractor.sv
// ----------------------------------------------------------------------------
// TLV tag/value extractor testbench
// Feeds response buffers built around the configured tag, with cut-off and
// noise buffers mixed in, under random gaps and output stalls. A local model
// of the tag search and value walk predicts every result, and each result is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_tlv_tag_value_extractor;

  localparam logic [1:0]  CfgSpare    = 2'd3;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ItemsPerCfg = 50;

  typedef enum logic [1:0] {Hunting, LenByte, Emitting, Finished} scan_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [7:0]       vbyte;
    logic             vlast;
    tve_pkg::status_t st;
  } value_res_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i  = 8'd0;
  logic        buffer_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [7:0]  value_byte_o;
  logic        value_last_o;
  logic [1:0]  status_o;
  logic        cfg_we_i     = 1'b0;
  logic [1:0]  cfg_index_i  = 2'd0;
  logic [31:0] cfg_data_i   = 32'd0;

  tlv_tag_value_extractor uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .buffer_end_i (buffer_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .value_byte_o (value_byte_o),
    .value_last_o (value_last_o),
    .status_o     (status_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  byte_req_t   bytes_to_send[$];
  value_res_t  results_due[$];
  byte_req_t   next_byte;
  value_res_t  due;
  int unsigned bad_results  = 0;
  int unsigned send_gap_pct = 0;
  int unsigned hold_pct     = 0;
  int unsigned stall_cycles = 0;
  int unsigned items_queued = 0;

  logic [31:0] tag_pattern_q = 32'd0;
  logic [2:0]  tag_length_q  = 3'd1;
  logic [7:0]  fixed_len_q   = 8'd0;

  logic [31:0] window_q    = 32'd0;
  logic [2:0]  fill_q      = 3'd0;
  scan_phase_e phase_q     = Hunting;
  logic [7:0]  remaining_q = 8'd0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned active_tag_len();
    if (tag_length_q == 3'd0) return 1;
    if (tag_length_q > tve_pkg::TagRegBytes) return tve_pkg::TagRegBytes;
    return 32'(tag_length_q);
  endfunction

  function automatic void clear_scan();
    window_q    = 32'd0;
    fill_q      = 3'd0;
    phase_q     = Hunting;
    remaining_q = 8'd0;
  endfunction

  function automatic void add_result(logic [7:0] vb, logic vl, tve_pkg::status_t st);
    value_res_t r;
    r.vbyte = vb;
    r.vlast = vl;
    r.st    = st;
    results_due = {results_due, r};
  endfunction

  function automatic void extract_byte(byte_req_t req);
    int unsigned len;
    logic [31:0] mask;
    len  = active_tag_len();
    mask = (len == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 32'd1);
    case (phase_q)
      Hunting: begin
        window_q = {window_q[23:0], req.data};
        if (fill_q < 3'd4) fill_q = fill_q + 3'd1;
        if (fill_q >= len && (window_q & mask) == (tag_pattern_q & mask)) begin
          if (fixed_len_q != 8'd0) begin
            remaining_q = fixed_len_q;
            phase_q     = Emitting;
          end else begin
            phase_q = LenByte;
          end
          if (req.last) add_result(8'd0, 1'b1, tve_pkg::StTrunc);
        end else if (req.last) begin
          add_result(8'd0, 1'b1, tve_pkg::StNotFound);
        end
      end
      LenByte: begin
        if (req.data == 8'd0) begin
          phase_q = Finished;
          add_result(8'd0, 1'b1, tve_pkg::StEmpty);
        end else begin
          remaining_q = req.data;
          phase_q     = Emitting;
          if (req.last) add_result(8'd0, 1'b1, tve_pkg::StTrunc);
        end
      end
      Emitting: begin
        if (remaining_q <= 8'd1) begin
          remaining_q = 8'd0;
          phase_q     = Finished;
          add_result(req.data, 1'b1, tve_pkg::StValue);
        end else if (req.last) begin
          add_result(8'd0, 1'b1, tve_pkg::StTrunc);
        end else begin
          remaining_q = remaining_q - 8'd1;
          add_result(req.data, 1'b0, tve_pkg::StValue);
        end
      end
      default: ;
    endcase
    if (req.last) clear_scan();
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) extract_byte(byte_req_t'({data_byte_i, buffer_end_i}));
      if (!in_valid_i || in_ready_o) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          next_byte = bytes_to_send.pop_front();
          in_valid_i   <= 1'b1;
          data_byte_i  <= next_byte.data;
          buffer_end_i <= next_byte.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          bad_results++;
          $display("%0t: unexpected result: value_byte=%h value_last=%b status=%0d",
                   $time, value_byte_o, value_last_o, status_o);
        end else begin
          due = results_due.pop_front();
          if (value_byte_o !== due.vbyte) begin
            bad_results++;
            $display("%0t: value_byte expected %h actual %h", $time, due.vbyte, value_byte_o);
          end
          if (value_last_o !== due.vlast) begin
            bad_results++;
            $display("%0t: value_last expected %b actual %b", $time, due.vlast, value_last_o);
          end
          if (status_o !== due.st) begin
            bad_results++;
            $display("%0t: status expected %0d actual %0d", $time, due.st, status_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= hold_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("tlv_tag_value_extractor: mismatch");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      tve_pkg::CfgTagPattern: tag_pattern_q = val;
      tve_pkg::CfgTagLength:  tag_length_q  = val[2:0];
      tve_pkg::CfgFixedLen:   fixed_len_q   = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] pattern, logic [2:0] len, logic [7:0] fixed);
    write_reg(tve_pkg::CfgTagPattern, pattern);
    write_reg(tve_pkg::CfgTagLength, ($urandom() << 3) | 32'(len));
    write_reg(tve_pkg::CfgFixedLen, ($urandom() << 8) | 32'(fixed));
  endtask

  task automatic queue_byte(logic [7:0] data, logic last);
    byte_req_t r;
    r.data = data;
    r.last = last;
    bytes_to_send = {bytes_to_send, r};
    items_queued++;
  endtask

  task automatic drain();
    while (bytes_to_send.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_buffer();
    logic [7:0]  body[$];
    int unsigned len;
    int unsigned vlen;
    int unsigned pick;
    int unsigned tag_end;
    int unsigned cut;
    int unsigned n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 10);
      for (int unsigned i = 0; i < n; i++)
        queue_byte(8'($urandom_range(255)), (i == n - 1) || ($urandom_range(9) == 0));
    end else begin
      len = active_tag_len();
      repeat ($urandom_range(0, 4)) body = {body, 8'($urandom_range(255))};
      for (int i = int'(len) - 1; i >= 0; i--) body = {body, tag_pattern_q[8*i +: 8]};
      tag_end = body.size() - 1;
      if (fixed_len_q == 8'd0) begin
        pick = $urandom_range(99);
        vlen = (pick < 12) ? 0 : (pick < 16) ? $urandom_range(100, 255) : $urandom_range(1, 8);
        body = {body, vlen[7:0]};
      end else begin
        vlen = fixed_len_q;
      end
      repeat (vlen) body = {body, 8'($urandom_range(255))};
      repeat ($urandom_range(0, 3)) body = {body, 8'($urandom_range(255))};
      cut = ($urandom_range(99) < 65) ? body.size() - 1 : $urandom_range(tag_end, body.size() - 1);
      for (int unsigned i = 0; i <= cut; i++) queue_byte(body[i], i == cut);
    end
  endtask

  initial begin
    int unsigned target;
    send_gap_pct = 6;
    hold_pct     = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: tag 00, one byte, length in band
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h80, 1'b1);
    drain();

    set_config(32'hFFFF_00FF, 3'd2, 8'd0);
    // tag at buffer start, full value, trailing byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h02, 1'b0);
    queue_byte(8'hAA, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h11, 1'b1);
    // tag missing
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // tag on final byte
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    // empty value, rest ignored
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h11, 1'b1);
    // length on final byte, nonzero then zero
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h03, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    // value cut off by buffer end
    queue_byte(8'h7E, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h03, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h02, 1'b1);
    drain();

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 6 : (mode == 1) ? 48 : 0;
      hold_pct     = (mode == 0) ? 48 : (mode == 1) ? 6 : 0;
      for (int k = 0; k < 4; k++) begin
        if (mode == 0 && k == 0) begin
          set_config(32'h0000_0000, 3'd0, 8'd0);
          write_reg(CfgSpare, $urandom());
        end else if (mode == 0 && k == 1) begin
          set_config(32'hFFFF_FFFF, 3'd7, 8'd255);
        end else if (mode == 1 && k == 0) begin
          set_config($urandom(), 3'd4, 8'd1);
        end else begin
          set_config($urandom(),
                     ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1, 4)),
                     ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(1, 6)));
        end
        target = items_queued + ItemsPerCfg;
        while (items_queued < target) queue_buffer();
        drain();
      end
    end

    if (bad_results == 0) begin
      $display("tlv_tag_value_extractor: match");
    end else begin
      $display("tlv_tag_value_extractor: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/tve_pkg.sv
hw/rtl/tve_cell.sv
hw/rtl/tlv_tag_value_extractor.sv
hw/rtl/tve_checker.sv
verif/tb_tlv_tag_value_extractor.sv
